### rtl/pivot_partition_swap_count_assert.svh
// Assertion macros for the RTL of the partition block.
// Each macro checks one implication on the rising clock edge and is
// turned off while the asynchronous reset is asserted.
`ifndef PIVOT_PARTITION_SWAP_COUNT_ASSERT_SVH
`define PIVOT_PARTITION_SWAP_COUNT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define PPSC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PPSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define PPSC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define PPSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/ppsc_pkg.sv
`default_nettype none

package ppsc_pkg;

	// Store geometry.
	localparam int DEPTH     = 16;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int DATA_W    = 16;
	localparam int OUT_IDX_W = 6;
	localparam int SWAP_W    = 6;

	// Datapath operations selected by the microcode.
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_LOAD      = 4'd0;
	localparam logic [OP_W-1:0] OP_SCAN_INIT = 4'd1;
	localparam logic [OP_W-1:0] OP_SCAN_RD   = 4'd2;
	localparam logic [OP_W-1:0] OP_SCAN_EVAL = 4'd3;
	localparam logic [OP_W-1:0] OP_PIV_RD    = 4'd4;
	localparam logic [OP_W-1:0] OP_PIV_WR1   = 4'd5;
	localparam logic [OP_W-1:0] OP_PIV_WR2   = 4'd6;
	localparam logic [OP_W-1:0] OP_PASS_RD   = 4'd7;
	localparam logic [OP_W-1:0] OP_PASS_EVAL = 4'd8;
	localparam logic [OP_W-1:0] OP_PASS_SWAP = 4'd9;
	localparam logic [OP_W-1:0] OP_EMIT_INIT = 4'd10;
	localparam logic [OP_W-1:0] OP_EMIT_RD   = 4'd11;
	localparam logic [OP_W-1:0] OP_EMIT_OUT  = 4'd12;

	// Datapath flags tested by conditional jumps.
	typedef struct packed {
		logic load_end;
		logic scan_more;
		logic all_below;
		logic pass_go;
		logic pass_swap;
		logic emit_more;
	} status_t;

	// Control handed from the sequencer to the datapath.
	typedef struct packed {
		logic [OP_W-1:0] op;
	} ctrl_t;

endpackage

`default_nettype wire

### rtl/ppsc_seq.sv
`default_nettype none

module ppsc_seq (
	input  wire                clk,
	input  wire                arst_n,
	input  wire ppsc_pkg::status_t status,
	output ppsc_pkg::ctrl_t    ctrl
);

	localparam int UPC_W  = 4;
	localparam int COND_W = 3;

	// Jump conditions.
	localparam logic [COND_W-1:0] C_ALWAYS    = 3'd0;
	localparam logic [COND_W-1:0] C_LOAD_END  = 3'd1;
	localparam logic [COND_W-1:0] C_SCAN_MORE = 3'd2;
	localparam logic [COND_W-1:0] C_ALL_BELOW = 3'd3;
	localparam logic [COND_W-1:0] C_PASS_GO   = 3'd4;
	localparam logic [COND_W-1:0] C_PASS_SWAP = 3'd5;
	localparam logic [COND_W-1:0] C_EMIT_MORE = 3'd6;

	// Program steps.
	localparam logic [UPC_W-1:0] S_IDLE      = 4'd0;
	localparam logic [UPC_W-1:0] S_SCAN_INIT = 4'd1;
	localparam logic [UPC_W-1:0] S_SCAN_RD   = 4'd2;
	localparam logic [UPC_W-1:0] S_SCAN_EVAL = 4'd3;
	localparam logic [UPC_W-1:0] S_PIV_RD    = 4'd4;
	localparam logic [UPC_W-1:0] S_PIV_WR1   = 4'd5;
	localparam logic [UPC_W-1:0] S_PIV_WR2   = 4'd6;
	localparam logic [UPC_W-1:0] S_PASS_RD   = 4'd7;
	localparam logic [UPC_W-1:0] S_PASS_EVAL = 4'd8;
	localparam logic [UPC_W-1:0] S_PASS_SWAP = 4'd9;
	localparam logic [UPC_W-1:0] S_EMIT_INIT = 4'd10;
	localparam logic [UPC_W-1:0] S_EMIT_RD   = 4'd11;
	localparam logic [UPC_W-1:0] S_EMIT_OUT  = 4'd12;

	typedef struct packed {
		logic [ppsc_pkg::OP_W-1:0] op;
		logic [COND_W-1:0]         cond;
		logic [UPC_W-1:0]          jt;
		logic [UPC_W-1:0]          jf;
	} uword_t;

	// Control store: operation, condition, target when true, target when false.
	function automatic uword_t rom(input logic [UPC_W-1:0] step);
		uword_t w;
		unique case (step)
			S_IDLE:      w = '{ppsc_pkg::OP_LOAD,      C_LOAD_END,  S_SCAN_INIT, S_IDLE};
			S_SCAN_INIT: w = '{ppsc_pkg::OP_SCAN_INIT, C_ALWAYS,    S_SCAN_RD,   S_SCAN_RD};
			S_SCAN_RD:   w = '{ppsc_pkg::OP_SCAN_RD,   C_ALWAYS,    S_SCAN_EVAL, S_SCAN_EVAL};
			S_SCAN_EVAL: w = '{ppsc_pkg::OP_SCAN_EVAL, C_SCAN_MORE, S_SCAN_RD,   S_PIV_RD};
			S_PIV_RD:    w = '{ppsc_pkg::OP_PIV_RD,    C_ALL_BELOW, S_EMIT_INIT, S_PIV_WR1};
			S_PIV_WR1:   w = '{ppsc_pkg::OP_PIV_WR1,   C_ALWAYS,    S_PIV_WR2,   S_PIV_WR2};
			S_PIV_WR2:   w = '{ppsc_pkg::OP_PIV_WR2,   C_ALWAYS,    S_PASS_RD,   S_PASS_RD};
			S_PASS_RD:   w = '{ppsc_pkg::OP_PASS_RD,   C_PASS_GO,   S_PASS_EVAL, S_EMIT_INIT};
			S_PASS_EVAL: w = '{ppsc_pkg::OP_PASS_EVAL, C_PASS_SWAP, S_PASS_SWAP, S_PASS_RD};
			S_PASS_SWAP: w = '{ppsc_pkg::OP_PASS_SWAP, C_ALWAYS,    S_PASS_RD,   S_PASS_RD};
			S_EMIT_INIT: w = '{ppsc_pkg::OP_EMIT_INIT, C_ALWAYS,    S_EMIT_RD,   S_EMIT_RD};
			S_EMIT_RD:   w = '{ppsc_pkg::OP_EMIT_RD,   C_ALWAYS,    S_EMIT_OUT,  S_EMIT_OUT};
			S_EMIT_OUT:  w = '{ppsc_pkg::OP_EMIT_OUT,  C_EMIT_MORE, S_EMIT_RD,   S_IDLE};
			default:     w = '{ppsc_pkg::OP_LOAD,      C_ALWAYS,    S_IDLE,      S_IDLE};
		endcase
		return w;
	endfunction

	logic [UPC_W-1:0] upc_q;
	uword_t           cw;
	logic             taken;

	// Fetch the current control word and resolve the branch.
	always_comb begin
		cw = rom(upc_q);
		unique case (cw.cond)
			C_ALWAYS:    taken = 1'b1;
			C_LOAD_END:  taken = status.load_end;
			C_SCAN_MORE: taken = status.scan_more;
			C_ALL_BELOW: taken = status.all_below;
			C_PASS_GO:   taken = status.pass_go;
			C_PASS_SWAP: taken = status.pass_swap;
			C_EMIT_MORE: taken = status.emit_more;
			default:     taken = 1'b1;
		endcase
	end

	assign ctrl.op = cw.op;

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_IDLE;
		end else begin
			upc_q <= taken ? cw.jt : cw.jf;
		end
	end

endmodule

`default_nettype wire

### rtl/pivot_partition_swap_count.sv
// Loading takes an element per cycle when idle; the set's last transaction starts the partition.
// The first result follows a scan init, a read and an evaluation per element, and a pivot read;
// unless all are below the pivot, the pivot swap writes, pass steps (read, evaluate, swap if needed), a
// final check; then an emit init. Each result is read, then output; the receiver cannot stall them;
// busy is high from the cycle after the accepting edge through the cycle of the last result.
// Reset clears the sequencer, the counters and the pivot register; store contents are undefined.
`default_nettype none

`include "pivot_partition_swap_count_assert.svh"

module pivot_partition_swap_count (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   pivot_we,
	input  wire signed [ppsc_pkg::DATA_W-1:0]     pivot_value,
	input  wire                                   start,
	output logic                                  busy,
	input  wire signed [ppsc_pkg::DATA_W-1:0]     element_value,
	input  wire                                   is_last,
	output logic                                  out_strobe,
	output logic       [ppsc_pkg::OUT_IDX_W-1:0]  out_index,
	output logic signed [ppsc_pkg::DATA_W-1:0]    out_value,
	output logic       [ppsc_pkg::SWAP_W-1:0]     swap_total,
	output logic                                  out_last
);

	localparam int IDX_W  = ppsc_pkg::IDX_W;
	localparam int CNT_W  = ppsc_pkg::CNT_W;
	localparam int DATA_W = ppsc_pkg::DATA_W;

	ppsc_pkg::status_t status;
	ppsc_pkg::ctrl_t   ctrl;

	logic signed [DATA_W-1:0] pivot_q;
	logic signed [DATA_W-1:0] mem [ppsc_pkg::DEPTH];
	logic signed [DATA_W-1:0] rd_a_q;
	logic signed [DATA_W-1:0] rd_b_q;

	logic [IDX_W-1:0]  load_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  c_q;
	logic [IDX_W-1:0]  slot_q;
	logic [IDX_W-1:0]  i_q;
	logic [IDX_W-1:0]  d_q;
	logic [IDX_W-1:0]  k_q;
	logic [ppsc_pkg::SWAP_W-1:0] swaps_q;

	logic              accept;
	logic              k_more;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic signed [DATA_W-1:0] wdata;
	logic              re;
	logic [IDX_W-1:0]  raddr_a;
	logic [IDX_W-1:0]  raddr_b;

	ppsc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	assign busy   = (ctrl.op != ppsc_pkg::OP_LOAD);
	assign accept = start && !busy;
	assign k_more = (CNT_W'(k_q) + CNT_W'(1)) != n_q;

	// Flags for the sequencer's conditional jumps.
	always_comb begin
		status.load_end  = start && (is_last || load_q == IDX_W'(ppsc_pkg::DEPTH - 1));
		status.scan_more = k_more;
		status.all_below = (c_q == n_q);
		status.pass_go   = (CNT_W'(i_q) < c_q) && (CNT_W'(d_q) > c_q);
		status.pass_swap = (rd_a_q > pivot_q) && (rd_b_q < pivot_q);
		status.emit_more = k_more;
	end

	// Store write port and read addresses, decoded from the operation.
	always_comb begin
		we      = 1'b0;
		waddr   = load_q;
		wdata   = element_value;
		re      = 1'b0;
		raddr_a = k_q;
		raddr_b = d_q;
		unique case (ctrl.op)
			ppsc_pkg::OP_LOAD: begin
				we = accept;
			end
			ppsc_pkg::OP_SCAN_RD, ppsc_pkg::OP_EMIT_RD: begin
				re = 1'b1;
			end
			ppsc_pkg::OP_PIV_RD: begin
				re      = 1'b1;
				raddr_a = slot_q;
				raddr_b = c_q[IDX_W-1:0];
			end
			ppsc_pkg::OP_PIV_WR1: begin
				we    = 1'b1;
				waddr = slot_q;
				wdata = rd_b_q;
			end
			ppsc_pkg::OP_PIV_WR2: begin
				we    = 1'b1;
				waddr = c_q[IDX_W-1:0];
				wdata = rd_a_q;
			end
			ppsc_pkg::OP_PASS_RD: begin
				re      = 1'b1;
				raddr_a = i_q;
			end
			ppsc_pkg::OP_PASS_EVAL: begin
				we    = status.pass_swap;
				waddr = i_q;
				wdata = rd_b_q;
			end
			ppsc_pkg::OP_PASS_SWAP: begin
				we    = 1'b1;
				waddr = d_q;
				wdata = rd_a_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Element store with two registered read ports.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_a_q <= mem[raddr_a];
			rd_b_q <= mem[raddr_b];
		end
	end

	// Pivot register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pivot_q <= '0;
		end else if (pivot_we) begin
			pivot_q <= pivot_value;
		end
	end

	// Counters and pointers of the partition datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q  <= '0;
			n_q     <= '0;
			c_q     <= '0;
			slot_q  <= '0;
			i_q     <= '0;
			d_q     <= '0;
			k_q     <= '0;
			swaps_q <= '0;
		end else begin
			case (ctrl.op)
				ppsc_pkg::OP_LOAD: begin
					if (accept) begin
						if (status.load_end) begin
							load_q <= '0;
							n_q    <= CNT_W'(load_q) + CNT_W'(1);
						end else begin
							load_q <= load_q + IDX_W'(1);
						end
					end
				end
				ppsc_pkg::OP_SCAN_INIT: begin
					k_q     <= '0;
					c_q     <= '0;
					slot_q  <= '0;
					swaps_q <= '0;
				end
				ppsc_pkg::OP_SCAN_EVAL: begin
					if (rd_a_q < pivot_q) begin
						c_q <= c_q + CNT_W'(1);
					end
					if (rd_a_q == pivot_q) begin
						slot_q <= k_q;
					end
					k_q <= k_q + IDX_W'(1);
				end
				ppsc_pkg::OP_PIV_WR2: begin
					i_q <= '0;
					d_q <= IDX_W'(n_q - CNT_W'(1));
				end
				ppsc_pkg::OP_PASS_EVAL: begin
					// Without a swap: move the left, the right, or both pointers.
					if (!status.pass_swap) begin
						if ((rd_a_q < pivot_q) && (rd_b_q > pivot_q)) begin
							d_q <= d_q - IDX_W'(1);
							i_q <= i_q + IDX_W'(1);
						end else if ((rd_a_q > pivot_q) && (rd_b_q > pivot_q)) begin
							d_q <= d_q - IDX_W'(1);
						end else begin
							i_q <= i_q + IDX_W'(1);
						end
					end
				end
				ppsc_pkg::OP_PASS_SWAP: begin
					d_q     <= d_q - IDX_W'(1);
					i_q     <= i_q + IDX_W'(1);
					swaps_q <= swaps_q + ppsc_pkg::SWAP_W'(1);
				end
				ppsc_pkg::OP_EMIT_INIT: begin
					k_q <= '0;
				end
				ppsc_pkg::OP_EMIT_OUT: begin
					k_q <= k_q + IDX_W'(1);
				end
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

	// Result transaction, one per stored element.
	assign out_strobe = (ctrl.op == ppsc_pkg::OP_EMIT_OUT);
	assign out_index  = ppsc_pkg::OUT_IDX_W'(k_q);
	assign out_value  = rd_a_q;
	assign swap_total = swaps_q;
	assign out_last   = !k_more;

	`PPSC_ASSERT_IMPL(a_strobe_busy, clk, arst_n, out_strobe, busy, "result while idle")
	`PPSC_ASSERT_NEXT(a_end_starts_scan, clk, arst_n, accept && status.load_end, ctrl.op == ppsc_pkg::OP_SCAN_INIT, "set end did not start scan")
	`PPSC_ASSERT_NEXT(a_last_goes_idle, clk, arst_n, out_strobe && out_last, !busy, "not idle after last result")
	`PPSC_ASSERT_IMPL(a_right_above_slot, clk, arst_n, ctrl.op == ppsc_pkg::OP_PASS_RD, CNT_W'(d_q) >= c_q, "right pointer crossed pivot slot")
	`PPSC_ASSERT_NEXT(a_swap_counted, clk, arst_n, ctrl.op == ppsc_pkg::OP_PASS_SWAP, swaps_q == $past(swaps_q) + ppsc_pkg::SWAP_W'(1), "swap not counted")

endmodule

`default_nettype wire

### tb/sv/pivot_partition_swap_count_tb.sv
`timescale 1ns / 100ps
`default_nettype none

module pivot_partition_swap_count_tb;

	localparam int DEPTH     = ppsc_pkg::DEPTH;
	localparam int DATA_W    = ppsc_pkg::DATA_W;
	localparam int OUT_IDX_W = ppsc_pkg::OUT_IDX_W;
	localparam int SWAP_W    = ppsc_pkg::SWAP_W;

	localparam int RESET_CYCLES   = 12;
	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int GAP_PERCENT    = 31;
	localparam int PHASE_ITEMS    = 52;
	// Accepted transactions in this window are sent back to back.
	localparam int QUIET_FROM     = 200;
	localparam int QUIET_TO       = 300;

	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} load_item_t;

	typedef struct {
		logic [OUT_IDX_W-1:0]     index;
		logic signed [DATA_W-1:0] value;
		logic [SWAP_W-1:0]        swaps;
		logic                     last;
	} emit_t;

	logic                     clk           = 1'b0;
	logic                     arst_n        = 1'b0;
	logic                     pivot_we      = 1'b0;
	logic signed [DATA_W-1:0] pivot_value   = '0;
	logic                     start         = 1'b0;
	logic signed [DATA_W-1:0] element_value = '0;
	logic                     is_last       = 1'b0;
	wire                      busy;
	wire                      out_strobe;
	wire [OUT_IDX_W-1:0]      out_index;
	wire signed [DATA_W-1:0]  out_value;
	wire [SWAP_W-1:0]         swap_total;
	wire                      out_last;

	// Testbench copy of the block state.
	logic signed [DATA_W-1:0] mirror_store [DEPTH];
	logic signed [DATA_W-1:0] pivot_now = '0;
	int                       fill_level = 0;

	load_item_t pending_loads [$];
	emit_t      expected_emits [$];

	int loads_accepted = 0;
	int sets_done      = 0;
	int emits_checked  = 0;
	int pivots_written = 0;
	int mismatch_count = 0;
	int idle_cycles    = 0;

	pivot_partition_swap_count u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pivot_we     (pivot_we),
		.pivot_value  (pivot_value),
		.start        (start),
		.busy         (busy),
		.element_value(element_value),
		.is_last      (is_last),
		.out_strobe   (out_strobe),
		.out_index    (out_index),
		.out_value    (out_value),
		.swap_total   (swap_total),
		.out_last     (out_last)
	);

	// 4 ns clock.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Partition the first n stored elements around the current pivot and queue
	// one expected result per position.
	task automatic predict_partition(input int n);
		int below;
		int slot;
		int lp;
		int rp;
		int swaps;
		int k;
		logic signed [DATA_W-1:0] tmp;
		emit_t e;
		below = 0;
		slot  = 0;
		swaps = 0;
		for (k = 0; k < n; k++) begin
			if (mirror_store[k] < pivot_now)
				below++;
			if (mirror_store[k] == pivot_now)
				slot = k;
		end
		// With every element below the pivot there is no pivot slot and no pass.
		if (below < n) begin
			tmp                 = mirror_store[slot];
			mirror_store[slot]  = mirror_store[below];
			mirror_store[below] = tmp;
			rp = n - 1;
			lp = 0;
			// The right pointer never passes below the pivot slot.
			while (lp < below && rp > below) begin
				if (mirror_store[lp] > pivot_now && mirror_store[rp] < pivot_now) begin
					tmp              = mirror_store[lp];
					mirror_store[lp] = mirror_store[rp];
					mirror_store[rp] = tmp;
					swaps++;
					lp++;
					rp--;
				end else if (mirror_store[lp] < pivot_now && mirror_store[rp] > pivot_now) begin
					lp++;
					rp--;
				end else if (mirror_store[lp] > pivot_now && mirror_store[rp] > pivot_now) begin
					rp--;
				end else begin
					lp++;
				end
			end
		end
		for (k = 0; k < n; k++) begin
			e.index = k[OUT_IDX_W-1:0];
			e.value = mirror_store[k];
			e.swaps = swaps[SWAP_W-1:0];
			e.last  = (k == n - 1);
			expected_emits.push_back(e);
		end
	endtask

	task automatic add_load(input int value, input logic last);
		load_item_t it;
		it.value = value[DATA_W-1:0];
		it.last  = last;
		pending_loads.push_back(it);
	endtask

	// Values cluster around the pivot so that equalities and near misses are common.
	function automatic int pick_value(input int pv);
		int v;
		int r;
		r = $urandom_range(99);
		if (r < 40) begin
			v = pv + int'($urandom_range(6)) - 3;
			if (v > 32767)
				v = 32767;
			if (v < -32768)
				v = -32768;
		end else if (r < 70) begin
			v = int'($signed(16'($urandom)));
		end else begin
			case ($urandom_range(2))
				0:       v = -32768;
				1:       v = 32767;
				default: v = pv;
			endcase
		end
		return v;
	endfunction

	// One whole set; a full store ends the set whatever is_last says.
	task automatic add_random_set(input int pv, output int count);
		int r;
		int k;
		r = $urandom_range(99);
		if (r < 10)
			count = DEPTH;
		else if (r < 25)
			count = $urandom_range(DEPTH - 1, 9);
		else
			count = $urandom_range(8, 1);
		for (k = 0; k < count; k++) begin
			if (k < count - 1)
				add_load(pick_value(pv), 1'b0);
			else if (count == DEPTH)
				add_load(pick_value(pv), 1'($urandom_range(1)));
			else
				add_load(pick_value(pv), 1'b1);
		end
	endtask

	// Wait until every transaction is sent and every result has come out.
	task automatic settle();
		do
			@(negedge clk);
		while (pending_loads.size() != 0 || start || busy || expected_emits.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_pivot(input int v);
		settle();
		@(posedge clk);
		pivot_we    <= 1'b1;
		pivot_value <= v[DATA_W-1:0];
		@(posedge clk);
		pivot_we  <= 1'b0;
		pivot_now  = v[DATA_W-1:0];
		pivots_written++;
	endtask

	// Driver: holds a transaction while busy, otherwise takes the next one or idles.
	always @(posedge clk) begin : drive_blk
		load_item_t it;
		logic gap;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!(start && busy)) begin
			if (start) begin
				mirror_store[fill_level] = element_value;
				fill_level++;
				loads_accepted++;
				if (is_last || fill_level == DEPTH) begin
					predict_partition(fill_level);
					fill_level = 0;
					sets_done++;
				end
			end
			gap = (loads_accepted < QUIET_FROM || loads_accepted >= QUIET_TO)
				&& ($urandom_range(99) < GAP_PERCENT);
			if (pending_loads.size() != 0 && !gap) begin
				it = pending_loads.pop_front();
				start         <= 1'b1;
				element_value <= it.value;
				is_last       <= it.last;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every strobed result is checked against the oldest expectation.
	always @(posedge clk) begin : monitor_blk
		emit_t want;
		if (arst_n && out_strobe) begin
			if (expected_emits.size() == 0) begin
				$error("unexpected result at index %0d, value %0d", out_index, out_value);
				mismatch_count++;
			end else begin
				want = expected_emits.pop_front();
				if (out_index !== want.index) begin
					$error("out_index: expected %0d, actual %0d", want.index, out_index);
					mismatch_count++;
				end
				if (out_value !== want.value) begin
					$error("out_value: expected %0d, actual %0d", want.value, out_value);
					mismatch_count++;
				end
				if (swap_total !== want.swaps) begin
					$error("swap_total: expected %0d, actual %0d", want.swaps, swap_total);
					mismatch_count++;
				end
				if (out_last !== want.last) begin
					$error("out_last: expected %0d, actual %0d", want.last, out_last);
					mismatch_count++;
				end
			end
			emits_checked++;
		end
	end

	// Watchdog on cycles with no transaction, no result and no register write.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || out_strobe || pivot_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Stimulus: directed sets first, then random phases with different pivots.
	initial begin : stim_blk
		int phase_pivots [7];
		int p;
		int added;
		int count;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Pivot zero: one swap and one double step, then a single element below
		// the pivot, then a set without the pivot value.
		set_pivot(0);
		@(negedge clk);
		add_load(32767, 1'b0);
		add_load(-32768, 1'b0);
		add_load(0, 1'b0);
		add_load(5, 1'b0);
		add_load(-2, 1'b1);
		add_load(-32768, 1'b1);
		add_load(3, 1'b0);
		add_load(-1, 1'b0);
		add_load(7, 1'b0);
		add_load(-5, 1'b1);
		// Both pointers at elements above the pivot, then both below.
		add_load(5, 1'b0);
		add_load(6, 1'b0);
		add_load(0, 1'b0);
		add_load(-1, 1'b0);
		add_load(8, 1'b0);
		add_load(-2, 1'b1);
		add_load(-4, 1'b0);
		add_load(0, 1'b0);
		add_load(3, 1'b0);
		add_load(-6, 1'b1);

		// Pivot at both ends of its range.
		set_pivot(32767);
		@(negedge clk);
		add_load(32767, 1'b0);
		add_load(-32768, 1'b1);
		set_pivot(-32768);
		@(negedge clk);
		add_load(-32768, 1'b1);

		phase_pivots[0] = -32768;
		phase_pivots[1] = int'($urandom_range(8)) - 4;
		phase_pivots[2] = 32767;
		phase_pivots[3] = int'($signed(16'($urandom)));
		phase_pivots[4] = 0;
		phase_pivots[5] = int'($urandom_range(8)) - 4;
		phase_pivots[6] = int'($signed(16'($urandom)));

		for (p = 0; p < 7; p++) begin
			set_pivot(phase_pivots[p]);
			@(negedge clk);
			added = 0;
			while (added < PHASE_ITEMS) begin
				add_random_set(phase_pivots[p], count);
				added += count;
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_emits.size() != 0) begin
			$error("%0d expected results never came out", expected_emits.size());
			mismatch_count++;
		end
		$display("Covered %0d loads in %0d partitioned sets, %0d results checked,",
			loads_accepted, sets_done, emits_checked);
		$display("under %0d pivot register writes; %0d mismatches.",
			pivots_written, mismatch_count);
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

`default_nettype wire
